@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the outlet wall collision block.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define POWC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define POWC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/powc_pkg.sv @@
// Package of the parabolic outlet wall collision block: types, register codes and constants.
// No dependencies; the divider, speed, reflection, top-level and checker files import it.
package powc_pkg;

    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_MEAN_VELOCITY = 2'd0,
        REG_PROFILE_AXIS  = 2'd1,
        REG_CHANNEL_WIDTH = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    localparam logic [31:0] MEAN_VELOCITY_RST = 32'd0;
    localparam logic [1:0]  PROFILE_AXIS_RST  = 2'd0;
    localparam logic [30:0] CHANNEL_WIDTH_RST = 31'd65536;

    // Divider: 48 quotient bits, two restoring steps per stage.
    localparam int DIV_STEPS           = 48;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;

    localparam int S_W = 49;
    localparam logic [47:0] S_CLAMP = 48'h8000_0000_0000;
    localparam logic signed [63:0] R_FLOOR = -64'sh2000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic [31:0]        uniform_draw;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic               removed;
    } result_t;

    typedef struct packed {
        logic signed [31:0] mean_velocity;
        logic [1:0]         profile_axis;
        logic [30:0]        channel_width;
    } cfg_t;

    typedef struct packed {
        item_t       item;
        logic        neg;
        logic        ovf;
        logic        zero;
        logic [30:0] rem;
        logic [15:0] dvd;
        logic [47:0] quo;
    } div_t;

endpackage

@@ rtl/powc_if.sv @@
// Stream interfaces for the collision items and the collision results.
// Depends on nothing; field widths follow the block's item and result formats.
interface powc_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [31:0]        uniform_draw;

    modport source (
        output valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z,
        output normal_x, normal_y, normal_z, uniform_draw,
        input  ready
    );
    modport sink (
        input  valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z,
        input  normal_x, normal_y, normal_z, uniform_draw,
        output ready
    );
endinterface

interface powc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic               removed;

    modport source (
        output valid, out_vel_x, out_vel_y, out_vel_z, removed,
        input  ready
    );
    modport sink (
        input  valid, out_vel_x, out_vel_y, out_vel_z, removed,
        output ready
    );
endinterface

@@ rtl/powc_div.sv @@
// Pipelined restoring divider that maps the selected position to the profile coordinate s.
// Depends on powc_pkg.
module powc_div
    import powc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  cfg_t                cfg,
    input  logic                in_valid,
    input  item_t               in_item,
    output logic                out_valid,
    output item_t               out_item,
    output logic signed [S_W-1:0] out_s
);

    div_t                    stage_reg [0:DIV_STAGES];
    logic [DIV_STAGES:0]     stage_vld_reg;
    logic                    out_vld_reg;
    item_t                   out_item_reg;
    logic signed [S_W-1:0]   out_s_reg;

    logic signed [31:0]      pos_sel;
    logic                    sel_none;
    logic [31:0]             pos_mag;
    div_t                    entry_next;
    logic [48:0]             quo_ceil;
    logic [47:0]             s_mag;
    logic signed [S_W-1:0]   s_next;

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    function automatic div_t div_step(input div_t d, input logic [30:0] dsr);
        logic [31:0] sh;
        logic [31:0] diff;
        div_t        o;
        o    = d;
        sh   = {d.rem, d.dvd[15]};
        diff = sh - {1'b0, dsr};
        if (sh >= {1'b0, dsr}) begin
            o.rem = diff[30:0];
            o.quo = {d.quo[46:0], 1'b1};
        end else begin
            o.rem = sh[30:0];
            o.quo = {d.quo[46:0], 1'b0};
        end
        o.dvd = {d.dvd[14:0], 1'b0};
        return o;
    endfunction

    function automatic div_t div_stage(input div_t d, input logic [30:0] dsr);
        div_t o;
        o = d;
        for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
            o = div_step(o, dsr);
        end
        return o;
    endfunction

    always_comb begin
        sel_none = 1'b0;
        pos_sel  = '0;
        unique case (axis_t'(cfg.profile_axis))
            AXIS_X:  pos_sel = in_item.pos_x;
            AXIS_Y:  pos_sel = in_item.pos_y;
            AXIS_Z:  pos_sel = in_item.pos_z;
            default: sel_none = 1'b1;
        endcase
        pos_mag = pos_sel[31] ? (32'd0 - $unsigned(pos_sel)) : $unsigned(pos_sel);

        entry_next.item = in_item;
        entry_next.neg  = pos_sel[31];
        entry_next.zero = sel_none || (cfg.channel_width == '0);
        // A quotient of 2^48 or more is far beyond the clamp of s.
        entry_next.ovf  = ({15'd0, pos_mag[31:16]} >= cfg.channel_width);
        entry_next.rem  = {15'd0, pos_mag[31:16]};
        entry_next.dvd  = pos_mag[15:0];
        entry_next.quo  = '0;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            stage_reg[0] <= entry_next;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        always_ff @(posedge clk) begin
            if (en) begin
                stage_reg[k] <= div_stage(stage_reg[k-1], cfg.channel_width);
            end
        end
    end

    // Negative dividends round the quotient toward minus infinity, then s is clamped.
    always_comb begin
        quo_ceil = {1'b0, stage_reg[DIV_STAGES].quo}
                 + {48'd0, (stage_reg[DIV_STAGES].neg && (stage_reg[DIV_STAGES].rem != '0))};
        if (stage_reg[DIV_STAGES].ovf || (quo_ceil > {1'b0, S_CLAMP})) begin
            s_mag = S_CLAMP;
        end else begin
            s_mag = quo_ceil[47:0];
        end
        if (stage_reg[DIV_STAGES].zero) begin
            s_next = '0;
        end else if (stage_reg[DIV_STAGES].neg) begin
            s_next = -$signed({1'b0, s_mag});
        end else begin
            s_next = $signed({1'b0, s_mag});
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            out_item_reg <= stage_reg[DIV_STAGES].item;
            out_s_reg    <= s_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stage_vld_reg <= '0;
            out_vld_reg   <= 1'b0;
        end else if (en) begin
            stage_vld_reg <= {stage_vld_reg[DIV_STAGES-1:0], in_valid};
            out_vld_reg   <= stage_vld_reg[DIV_STAGES];
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;
    assign out_s     = out_s_reg;

endmodule

@@ rtl/powc_speed.sv @@
// Outlet speed pipeline: r = s*(1-s) from s, then u0 = 6*mean_velocity*r, saturated.
// Depends on powc_pkg.
module powc_speed
    import powc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    input  item_t                 in_item,
    input  logic signed [S_W-1:0] in_s,
    output logic                  out_valid,
    output item_t                 out_item,
    output logic signed [31:0]    out_u0
);

    logic [5:0]            vld_reg;
    item_t                 item_reg [0:5];

    logic signed [S_W-1:0] a_s_reg;
    logic [47:0]           a_hh_reg;
    logic [47:0]           a_hl_reg;
    logic [47:0]           a_ll_reg;
    logic signed [S_W-1:0] b_s_reg;
    logic [62:0]           b_cq_reg;
    logic signed [62:0]    c_r_reg;
    logic signed [66:0]    d_pl_reg;
    logic signed [66:0]    d_ph_reg;
    logic signed [65:0]    e_u_reg;
    logic signed [31:0]    f_u0_reg;

    logic [48:0]           s_abs;
    logic [47:0]           hh_next;
    logic [47:0]           hl_next;
    logic [47:0]           ll_next;
    logic [95:0]           sq_sum;
    logic signed [63:0]    r_wide;
    logic signed [62:0]    r_next;
    logic signed [34:0]    mv_ext;
    logic signed [34:0]    m_gain;
    logic signed [66:0]    pl_next;
    logic signed [66:0]    ph_next;
    logic signed [97:0]    p_sum;
    logic signed [31:0]    u0_next;

    // s squared from three 24 x 24 partial products.
    always_comb begin
        s_abs   = in_s[S_W-1] ? $unsigned(-in_s) : $unsigned(in_s);
        hh_next = s_abs[47:24] * s_abs[47:24];
        hl_next = s_abs[47:24] * s_abs[23:0];
        ll_next = s_abs[23:0] * s_abs[23:0];
    end

    // floor(s*(2^32 - s)/2^32) equals s - ceil(s^2/2^32), clamped from below.
    always_comb begin
        sq_sum = {a_hh_reg, 48'd0} + {23'd0, a_hl_reg, 25'd0} + {48'd0, a_ll_reg}
               + 96'h0_FFFF_FFFF;
        r_wide = $signed({{15{b_s_reg[S_W-1]}}, b_s_reg}) - $signed({1'b0, b_cq_reg});
        r_next = (r_wide < R_FLOOR) ? R_FLOOR[62:0] : r_wide[62:0];
    end

    // Gain times r, split at bit 31 of r so each product stays near 32 x 32.
    always_comb begin
        mv_ext  = {{3{cfg.mean_velocity[31]}}, cfg.mean_velocity};
        m_gain  = (mv_ext <<< 2) + (mv_ext <<< 1);
        pl_next = m_gain * $signed({1'b0, c_r_reg[30:0]});
        ph_next = m_gain * $signed(c_r_reg[62:31]);
        p_sum   = ($signed({{31{d_ph_reg[66]}}, d_ph_reg}) <<< 31)
                + $signed({{31{d_pl_reg[66]}}, d_pl_reg});
        if ((e_u_reg[65:31] == '0) || (e_u_reg[65:31] == '1)) begin
            u0_next = e_u_reg[31:0];
        end else if (e_u_reg[65]) begin
            u0_next = 32'sh8000_0000;
        end else begin
            u0_next = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            item_reg[0] <= in_item;
            for (int i = 1; i < 6; i++) begin
                item_reg[i] <= item_reg[i-1];
            end
            a_s_reg  <= in_s;
            a_hh_reg <= hh_next;
            a_hl_reg <= hl_next;
            a_ll_reg <= ll_next;
            b_s_reg  <= a_s_reg;
            b_cq_reg <= sq_sum[94:32];
            c_r_reg  <= r_next;
            d_pl_reg <= pl_next;
            d_ph_reg <= ph_next;
            e_u_reg  <= p_sum[97:32];
            f_u0_reg <= u0_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    assign out_valid = vld_reg[5];
    assign out_item  = item_reg[5];
    assign out_u0    = f_u0_reg;

endmodule

@@ rtl/powc_refl.sv @@
// Reflection pipeline: normal and tangential split, reflected velocity and removal test.
// Depends on powc_pkg.
module powc_refl
    import powc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  item_t              in_item,
    input  logic signed [31:0] in_u0,
    output logic               out_valid,
    output result_t            out_result
);

    logic [5:0]          vld_reg;
    item_t               item_reg [0:3];
    logic signed [31:0]  u0_reg [0:1];

    logic signed [63:0]  pv_reg [0:2];
    logic signed [35:0]  dot_reg;
    logic signed [36:0]  w_reg;
    logic signed [64:0]  pa_reg [0:2];
    logic signed [35:0]  pb_reg [0:2];
    logic [33:0]         dabs_reg;
    logic                dnz_reg [0:2];
    logic signed [37:0]  dn_reg [0:2];
    logic signed [64:0]  qa_reg [0:2];
    logic signed [36:0]  qb_reg [0:2];
    logic [63:0]         da_reg;
    logic [33:0]         db_reg;
    logic [36:0]         wabs_reg [0:1];
    logic                wneg_reg [0:1];
    logic signed [38:0]  t_reg [0:2];
    logic signed [38:0]  wn_reg [0:2];
    logic [65:0]         prod_reg;
    result_t             res_reg;

    logic signed [31:0]  vel_a [0:2];
    logic signed [31:0]  nrm_a [0:2];
    logic signed [31:0]  nrm_c [0:2];
    logic signed [31:0]  nrm_d [0:2];
    logic signed [31:0]  vel_e [0:2];
    logic signed [63:0]  pv_next [0:2];
    logic signed [35:0]  dot_next;
    logic signed [36:0]  w_next;
    logic signed [35:0]  dot_neg;
    logic signed [64:0]  pa_next [0:2];
    logic signed [35:0]  pb_next [0:2];
    logic signed [67:0]  dn_sum [0:2];
    logic signed [64:0]  qa_next [0:2];
    logic signed [36:0]  qb_next [0:2];
    logic signed [36:0]  w_neg_val;
    logic signed [68:0]  wn_sum [0:2];
    logic signed [38:0]  t_next [0:2];
    logic signed [39:0]  o_full [0:2];
    logic signed [31:0]  o_sat [0:2];
    logic                rm_next;

    always_comb begin
        vel_a = '{in_item.vel_x, in_item.vel_y, in_item.vel_z};
        nrm_a = '{in_item.normal_x, in_item.normal_y, in_item.normal_z};
        nrm_c = '{item_reg[1].normal_x, item_reg[1].normal_y, item_reg[1].normal_z};
        nrm_d = '{item_reg[2].normal_x, item_reg[2].normal_y, item_reg[2].normal_z};
        vel_e = '{item_reg[3].vel_x, item_reg[3].vel_y, item_reg[3].vel_z};
    end

    // Normal component of the velocity: dot = sum of floor(v*n / 2^30).
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pv_next[i] = vel_a[i] * nrm_a[i];
        end
        dot_next = $signed({{2{pv_reg[0][63]}}, pv_reg[0][63:30]})
                 + $signed({{2{pv_reg[1][63]}}, pv_reg[1][63:30]})
                 + $signed({{2{pv_reg[2][63]}}, pv_reg[2][63:30]});
    end

    // Normal term w and the partial products of dot*n.
    always_comb begin
        w_next  = ($signed({{5{u0_reg[1][31]}}, u0_reg[1]}) <<< 1)
                + $signed({dot_reg[35], dot_reg});
        dot_neg = -dot_reg;
        for (int i = 0; i < 3; i++) begin
            pa_next[i] = $signed({1'b0, dot_reg[31:0]}) * nrm_c[i];
            pb_next[i] = $signed(dot_reg[35:32]) * nrm_c[i];
        end
    end

    always_comb begin
        w_neg_val = -w_reg;
        for (int i = 0; i < 3; i++) begin
            dn_sum[i]  = ($signed({{32{pb_reg[i][35]}}, pb_reg[i]}) <<< 32)
                       + $signed({{3{pa_reg[i][64]}}, pa_reg[i]});
            qa_next[i] = $signed({1'b0, w_reg[31:0]}) * nrm_d[i];
            qb_next[i] = $signed(w_reg[36:32]) * nrm_d[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t_next[i] = $signed({{7{vel_e[i][31]}}, vel_e[i]})
                      - $signed({dn_reg[i][37], dn_reg[i]});
            wn_sum[i] = ($signed({{32{qb_reg[i][36]}}, qb_reg[i]}) <<< 32)
                      + $signed({{4{qa_reg[i][64]}}, qa_reg[i]});
        end
    end

    // Reflected velocity with saturation, and the removal test.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_full[i] = -$signed({wn_reg[i][38], wn_reg[i]})
                      - $signed({t_reg[i][38], t_reg[i]});
            if ((o_full[i][39:31] == '0) || (o_full[i][39:31] == '1)) begin
                o_sat[i] = o_full[i][31:0];
            end else if (o_full[i][39]) begin
                o_sat[i] = 32'sh8000_0000;
            end else begin
                o_sat[i] = 32'sh7FFF_FFFF;
            end
        end
        rm_next = !wneg_reg[1]
               || (dnz_reg[2] && ({3'd0, prod_reg} >= {wabs_reg[1], 32'd0}));
    end

    always_ff @(posedge clk) begin
        if (en) begin
            item_reg[0] <= in_item;
            for (int i = 1; i < 4; i++) begin
                item_reg[i] <= item_reg[i-1];
            end
            u0_reg[0] <= in_u0;
            u0_reg[1] <= u0_reg[0];
            dot_reg   <= dot_next;
            w_reg     <= w_next;
            dabs_reg  <= dot_reg[35] ? dot_neg[33:0] : dot_reg[33:0];
            dnz_reg[0] <= (dot_reg != '0);
            dnz_reg[1] <= dnz_reg[0];
            dnz_reg[2] <= dnz_reg[1];
            da_reg    <= item_reg[2].uniform_draw * dabs_reg[31:0];
            db_reg    <= item_reg[2].uniform_draw * dabs_reg[33:32];
            wabs_reg[0] <= w_reg[36] ? w_neg_val : w_reg;
            wabs_reg[1] <= wabs_reg[0];
            wneg_reg[0] <= w_reg[36];
            wneg_reg[1] <= wneg_reg[0];
            prod_reg  <= {db_reg, 32'd0} + {2'd0, da_reg};
            for (int i = 0; i < 3; i++) begin
                pv_reg[i] <= pv_next[i];
                pa_reg[i] <= pa_next[i];
                pb_reg[i] <= pb_next[i];
                dn_reg[i] <= dn_sum[i][67:30];
                qa_reg[i] <= qa_next[i];
                qb_reg[i] <= qb_next[i];
                t_reg[i]  <= t_next[i];
                wn_reg[i] <= wn_sum[i][68:30];
            end
            res_reg.out_vel_x <= o_sat[0];
            res_reg.out_vel_y <= o_sat[1];
            res_reg.out_vel_z <= o_sat[2];
            res_reg.removed   <= rm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    assign out_valid  = vld_reg[5];
    assign out_result = res_reg;

endmodule

@@ rtl/parabolic_outlet_wall_collision.sv @@
// Top level of the parabolic outlet wall collision block: APB registers and the pipeline.
// Depends on powc_pkg, powc_if, powc_div, powc_speed and powc_refl.
//
// Each transaction on item describes one particle striking an outlet surface and yields
// exactly one transaction on result: the reflected velocity (Q16.16, saturated) and a
// removed flag. The block is one pipeline of 38 register stages; while nothing stalls, a
// new item is accepted in every cycle. The depth comes from the profile-coordinate divider
// (one entry stage, 24 stages of two restoring steps, one rounding stage), followed by six
// stages for the parabolic speed and six for the reflection. The whole pipeline advances
// together: it moves whenever the result register is empty or being taken, so item.ready
// follows result.ready and is high whenever no finished result waits. Registers sit on a
// 4-bit APB port: mean_velocity at 0x0, profile_axis at 0x4 and channel_width at 0x8;
// write them only while no particle is in flight. A profile axis of three or a zero
// channel width gives zero outlet speed.
module parabolic_outlet_wall_collision
    import powc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    powc_item_if.sink          item,
    powc_result_if.source      result
);

    cfg_t                  cfg_reg;
    logic                  en;
    logic                  reg_hit;
    item_t                 in_item;

    logic                  div_valid;
    item_t                 div_item;
    logic signed [S_W-1:0] div_s;
    logic                  spd_valid;
    item_t                 spd_item;
    logic signed [31:0]    spd_u0;
    logic                  res_valid;
    result_t               res;

    // Configuration registers; a write lands in the access phase.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[1:0] == 2'b00);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.mean_velocity <= MEAN_VELOCITY_RST;
            cfg_reg.profile_axis  <= PROFILE_AXIS_RST;
            cfg_reg.channel_width <= CHANNEL_WIDTH_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_MEAN_VELOCITY: cfg_reg.mean_velocity <= pwdata;
                REG_PROFILE_AXIS:  cfg_reg.profile_axis  <= pwdata[1:0];
                REG_CHANNEL_WIDTH: cfg_reg.channel_width <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_MEAN_VELOCITY: prdata = cfg_reg.mean_velocity;
                REG_PROFILE_AXIS:  prdata = {30'd0, cfg_reg.profile_axis};
                REG_CHANNEL_WIDTH: prdata = {1'b0, cfg_reg.channel_width};
                default:           prdata = '0;
            endcase
        end
    end

    // The pipeline moves as a whole whenever the result register can take a new value.
    assign en         = !res_valid || result.ready;
    assign item.ready = en;

    always_comb begin
        in_item.vel_x        = item.vel_x;
        in_item.vel_y        = item.vel_y;
        in_item.vel_z        = item.vel_z;
        in_item.pos_x        = item.pos_x;
        in_item.pos_y        = item.pos_y;
        in_item.pos_z        = item.pos_z;
        in_item.normal_x     = item.normal_x;
        in_item.normal_y     = item.normal_y;
        in_item.normal_z     = item.normal_z;
        in_item.uniform_draw = item.uniform_draw;
    end

    // Profile coordinate s = p / channel_width, clamped.
    powc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (item.valid),
        .in_item   (in_item),
        .out_valid (div_valid),
        .out_item  (div_item),
        .out_s     (div_s)
    );

    // Local outlet speed u0 from the parabola.
    powc_speed u_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .in_s      (div_s),
        .out_valid (spd_valid),
        .out_item  (spd_item),
        .out_u0    (spd_u0)
    );

    // Reflection and removal; its last stage is the result register.
    powc_refl u_refl (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (spd_valid),
        .in_item    (spd_item),
        .in_u0      (spd_u0),
        .out_valid  (res_valid),
        .out_result (res)
    );

    assign result.valid     = res_valid;
    assign result.out_vel_x = res.out_vel_x;
    assign result.out_vel_y = res.out_vel_y;
    assign result.out_vel_z = res.out_vel_z;
    assign result.removed   = res.removed;

endmodule

@@ rtl/powc_checker.sv @@
// Port-level checker for the outlet wall collision block, bound to the top level.
// Depends on powc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module powc_checker
    import powc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic [31:0]        result_vel_x,
    input logic [31:0]        result_vel_y,
    input logic [31:0]        result_vel_z,
    input logic               result_removed
);

    `POWC_ASSERT_NXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable({result_vel_x, result_vel_y, result_vel_z, result_removed}),
        "result changed while stalled")

    `POWC_ASSERT_IMP(a_ready_when_empty, !result_valid, item_ready, "item not taken while output empty")

    `POWC_ASSERT_IMP(a_ready_on_drain, result_valid && result_ready, item_ready, "item not taken while result drains")

    `POWC_ASSERT_IMP(a_axis_readback,
        (psel && penable && pwrite && paddr == {REG_PROFILE_AXIS, 2'b00})
            ##1 (psel && !pwrite && paddr == {REG_PROFILE_AXIS, 2'b00}),
        prdata == {30'd0, $past(pwdata[1:0])}, "profile axis readback mismatch")

endmodule

bind parabolic_outlet_wall_collision powc_checker u_powc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_vel_x   (result.out_vel_x),
    .result_vel_y   (result.out_vel_y),
    .result_vel_z   (result.out_vel_z),
    .result_removed (result.removed)
);

@@ tb/sv/tb_parabolic_outlet_wall_collision.sv @@
// Self-checking testbench of the parabolic outlet wall collision block.
// Depends on powc_pkg, powc_if and the RTL top level parabolic_outlet_wall_collision.
module tb_parabolic_outlet_wall_collision;
    import powc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_CYCLES = 60;
    localparam logic signed [127:0] LIM_WIDE = 128'sd1 <<< 62;
    localparam logic signed [127:0] LIM_R    = 128'sd1 <<< 61;
    localparam logic signed [127:0] LIM_OUT  = 128'sd1 <<< 31;
    localparam logic signed [127:0] S_LIM    = 128'sd1 <<< 47;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    powc_item_if   item_bus ();
    powc_result_if result_bus ();

    parabolic_outlet_wall_collision uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_bus.sink),
        .result  (result_bus.source)
    );

    // Shadow copy of the configuration registers, updated by every APB write.
    logic signed [31:0] cfg_mean_velocity;
    logic [1:0]         cfg_profile_axis;
    logic [30:0]        cfg_channel_width;

    item_t   particle_queue[$];   // particles waiting to be driven
    result_t bounce_queue[$];     // reflections the block still owes us
    item_t   driven_particle;
    logic    particle_taken;
    logic    quiet_mode;          // when set, neither side idles
    int      cycle_count;
    int      error_count;

    initial begin
        clk = 1'b0;
    end
    always #6 clk = ~clk;

    // floor(a*b / 2^sh), saturated to [-lim, lim-1]. The arithmetic shift floors.
    function automatic logic signed [127:0] mul_floor_sat(
        input logic signed [127:0] a,
        input logic signed [127:0] b,
        input int                  sh,
        input logic signed [127:0] lim
    );
        logic signed [127:0] q;
        q = (a * b) >>> sh;
        if (q > lim - 1)
            q = lim - 1;
        if (q < -lim)
            q = -lim;
        return q;
    endfunction

    // Local outlet speed from the parabolic profile; zero when the width is zero
    // or no axis is selected.
    function automatic logic signed [127:0] profile_speed(input logic signed [31:0] p);
        logic signed [127:0] num;
        logic signed [127:0] wdt;
        logic signed [127:0] s;
        logic signed [127:0] r;
        logic signed [127:0] m;
        if (cfg_channel_width == 0 || cfg_profile_axis > AXIS_Z)
            return 0;
        wdt = $signed({97'd0, cfg_channel_width});
        num = $signed(p) * (128'sd1 <<< 32);
        s = num / wdt;
        if (num < 0 && (num % wdt) != 0)
            s = s - 1;
        if (s > S_LIM)
            s = S_LIM;
        if (s < -S_LIM)
            s = -S_LIM;
        r = mul_floor_sat(s, (128'sd1 <<< 32) - s, 32, LIM_R);
        m = 6 * $signed(cfg_mean_velocity);
        return mul_floor_sat(m, r, 32, LIM_OUT);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [127:0] x);
        if (x > LIM_OUT - 1)
            return 32'sh7fff_ffff;
        if (x < -LIM_OUT)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // Reflection of one particle under the current register settings.
    function automatic result_t reflect_particle(input item_t it);
        logic signed [127:0] v[3];
        logic signed [127:0] n[3];
        logic signed [127:0] t[3];
        logic signed [127:0] dot;
        logic signed [127:0] u0;
        logic signed [127:0] w;
        logic signed [127:0] o[3];
        logic signed [31:0]  p;
        logic [127:0]        lhs;
        logic [127:0]        rhs;
        result_t             res;
        v[0] = it.vel_x;    v[1] = it.vel_y;    v[2] = it.vel_z;
        n[0] = it.normal_x; n[1] = it.normal_y; n[2] = it.normal_z;
        case (cfg_profile_axis)
            AXIS_Y:  p = it.pos_y;
            AXIS_Z:  p = it.pos_z;
            default: p = it.pos_x;
        endcase
        dot = 0;
        for (int i = 0; i < 3; i++)
            dot = dot + mul_floor_sat(v[i], n[i], 30, LIM_WIDE);
        for (int i = 0; i < 3; i++)
            t[i] = v[i] - mul_floor_sat(dot, n[i], 30, LIM_WIDE);
        u0 = profile_speed(p);
        w = 2 * u0 + dot;
        for (int i = 0; i < 3; i++)
            o[i] = -mul_floor_sat(w, n[i], 30, LIM_WIDE) - t[i];
        res.out_vel_x = sat32(o[0]);
        res.out_vel_y = sat32(o[1]);
        res.out_vel_z = sat32(o[2]);
        // Removal: outward normal term, or the draw reaches |w/u_p|.
        // A zero normal speed with inward w keeps the particle.
        if (w >= 0) begin
            res.removed = 1'b1;
        end else if (dot == 0) begin
            res.removed = 1'b0;
        end else begin
            lhs = {96'd0, it.uniform_draw} * (dot < 0 ? -dot : dot);
            rhs = (-w) <<< 32;
            res.removed = (lhs >= rhs);
        end
        return res;
    endfunction

    // Random particle. Most are physical hits on a unit normal inside the channel;
    // the rest are raw bit noise.
    function automatic item_t random_particle();
        item_t it;
        int    ax;
        logic signed [31:0] nv;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) < 8) begin
            ax = $urandom_range(0, 2);
            nv = $urandom_range(0, 1) ? 32'sh4000_0000 : -32'sh4000_0000;
            it.normal_x = 0;
            it.normal_y = 0;
            it.normal_z = 0;
            if ($urandom_range(0, 3) == 0) begin
                // Oblique normal of roughly unit length.
                it.normal_x = $signed(32'h2D41_3CCD);
                it.normal_y = $urandom_range(0, 1) ? $signed(32'h2D41_3CCD)
                                                  : -$signed(32'h2D41_3CCD);
            end else begin
                case (ax)
                    0: it.normal_x = nv;
                    1: it.normal_y = nv;
                    default: it.normal_z = nv;
                endcase
            end
            it.vel_x = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            it.vel_y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            it.vel_z = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            it.pos_x = $urandom_range(0, {1'b0, cfg_channel_width});
            it.pos_y = $urandom_range(0, {1'b0, cfg_channel_width});
            it.pos_z = $urandom_range(0, {1'b0, cfg_channel_width});
        end
        return it;
    endfunction

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MEAN_VELOCITY: cfg_mean_velocity = value;
            REG_PROFILE_AXIS:  cfg_profile_axis  = value[1:0];
            default:           cfg_channel_width = value[30:0];
        endcase
    endtask

    task automatic configure(input logic [31:0] mv, input logic [1:0] axis,
                             input logic [30:0] wd);
        write_reg(REG_MEAN_VELOCITY, mv);
        write_reg(REG_PROFILE_AXIS, {30'd0, axis});
        write_reg(REG_CHANNEL_WIDTH, {1'b0, wd});
    endtask

    // Waits until every queued particle has gone out and every reflection is back,
    // then lets the pipeline drain. This is also the pause the sender takes.
    task automatic drain();
        wait (particle_queue.size() == 0 && !item_bus.valid && bounce_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++)
            particle_queue.push_back(random_particle());
    endtask

    // Directed particles: field extremes, zero tangent, zero normal speed,
    // saturating velocities, draw extremes and positions at the channel edges.
    task automatic directed_set();
        item_t it;
        it = '0;
        particle_queue.push_back(it);
        it = {10{32'h7fff_ffff}};
        particle_queue.push_back(it);
        it = {10{32'h8000_0000}};
        particle_queue.push_back(it);
        it = {10{32'hffff_ffff}};
        particle_queue.push_back(it);
        // Velocity straight into the wall: zero tangent.
        it = '0;
        it.normal_z = 32'sh4000_0000;
        it.vel_z = -32'sh0003_0000;
        it.pos_x = 32'sh0000_8000;
        it.uniform_draw = 32'h0000_0000;
        particle_queue.push_back(it);
        it.uniform_draw = 32'hffff_ffff;
        particle_queue.push_back(it);
        it.uniform_draw = 32'h8000_0000;
        particle_queue.push_back(it);
        // Velocity along the wall: zero normal speed.
        it.vel_z = 0;
        it.vel_x = 32'sh0002_0000;
        particle_queue.push_back(it);
        // Outward normal speed: removed outright.
        it.vel_z = 32'sh0001_0000;
        particle_queue.push_back(it);
        // Extreme velocities on an oblique normal saturate the outputs.
        it.normal_x = 32'sh8000_0000;
        it.normal_z = 32'sh8000_0000;
        it.vel_x = 32'sh7fff_ffff;
        it.vel_z = 32'sh8000_0000;
        particle_queue.push_back(it);
        it.normal_x = 32'sh7fff_ffff;
        it.normal_y = 32'sh7fff_ffff;
        it.normal_z = 32'sh7fff_ffff;
        it.vel_y = 32'sh8000_0000;
        particle_queue.push_back(it);
        // Positions at the channel edges and beyond.
        it = '0;
        it.normal_y = -32'sh4000_0000;
        it.vel_y = 32'sh0001_0000;
        it.pos_x = 32'sh7fff_ffff;
        it.uniform_draw = 32'h4000_0000;
        particle_queue.push_back(it);
        it.pos_x = 32'sh8000_0000;
        particle_queue.push_back(it);
        it.pos_x = 32'sh0001_0000;
        particle_queue.push_back(it);
        it.pos_x = -32'sh0000_0001;
        particle_queue.push_back(it);
    endtask

    // Driver: a new particle goes out at the falling edge once the previous one
    // has been taken or the bus is idle.
    always @(negedge clk) begin
        if (!rst_n) begin
            item_bus.valid <= 1'b0;
            particle_taken = 1'b0;
        end else if (!item_bus.valid || particle_taken) begin
            particle_taken = 1'b0;
            if (particle_queue.size() != 0 && (quiet_mode || $urandom_range(0, 99) >= 16)) begin
                driven_particle = particle_queue.pop_front();
                item_bus.valid        <= 1'b1;
                item_bus.vel_x        <= driven_particle.vel_x;
                item_bus.vel_y        <= driven_particle.vel_y;
                item_bus.vel_z        <= driven_particle.vel_z;
                item_bus.pos_x        <= driven_particle.pos_x;
                item_bus.pos_y        <= driven_particle.pos_y;
                item_bus.pos_z        <= driven_particle.pos_z;
                item_bus.normal_x     <= driven_particle.normal_x;
                item_bus.normal_y     <= driven_particle.normal_y;
                item_bus.normal_z     <= driven_particle.normal_z;
                item_bus.uniform_draw <= driven_particle.uniform_draw;
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // The result side stalls at random unless the quiet stretch is on.
    always @(negedge clk) begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= quiet_mode || ($urandom_range(0, 99) >= 16);
    end

    // At each rising edge, an accepted particle is predicted right away, since
    // the registers only change while the block is idle.
    always @(posedge clk) begin
        if (rst_n && item_bus.valid && item_bus.ready) begin
            bounce_queue.push_back(reflect_particle(driven_particle));
            particle_taken = 1'b1;
        end
    end

    // Monitor: every result transaction is checked against the oldest prediction.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready) begin
            if (bounce_queue.size() == 0) begin
                $error("result transaction with no particle outstanding");
                error_count++;
            end else begin
                want = bounce_queue.pop_front();
                if (result_bus.out_vel_x !== want.out_vel_x) begin
                    $error("out_vel_x expected %0d actual %0d", want.out_vel_x,
                           result_bus.out_vel_x);
                    error_count++;
                end
                if (result_bus.out_vel_y !== want.out_vel_y) begin
                    $error("out_vel_y expected %0d actual %0d", want.out_vel_y,
                           result_bus.out_vel_y);
                    error_count++;
                end
                if (result_bus.out_vel_z !== want.out_vel_z) begin
                    $error("out_vel_z expected %0d actual %0d", want.out_vel_z,
                           result_bus.out_vel_z);
                    error_count++;
                end
                if (result_bus.removed !== want.removed) begin
                    $error("removed expected %0b actual %0b", want.removed,
                           result_bus.removed);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        error_count = 0;
        quiet_mode  = 1'b0;
        particle_taken = 1'b0;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        item_bus.valid = 1'b0;
        item_bus.vel_x = '0;
        item_bus.vel_y = '0;
        item_bus.vel_z = '0;
        item_bus.pos_x = '0;
        item_bus.pos_y = '0;
        item_bus.pos_z = '0;
        item_bus.normal_x = '0;
        item_bus.normal_y = '0;
        item_bus.normal_z = '0;
        item_bus.uniform_draw = '0;
        result_bus.ready = 1'b0;
        cfg_mean_velocity = MEAN_VELOCITY_RST;
        cfg_profile_axis  = PROFILE_AXIS_RST;
        cfg_channel_width = CHANNEL_WIDTH_RST;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings first, then a moderate profile with the directed set and a random burst.
        directed_set();
        drain();
        configure(32'sh0000_8000, AXIS_X, 31'h0001_0000);
        directed_set();
        random_burst(60);
        drain();

        // Y axis, wide channel; this phase runs with no idling on either side.
        quiet_mode = 1'b1;
        configure(32'sh0003_0000, AXIS_Y, 31'h0010_0000);
        random_burst(80);
        drain();
        quiet_mode = 1'b0;

        // Z axis, most negative mean velocity, narrowest channel.
        configure(32'sh8000_0000, AXIS_Z, 31'd1);
        random_burst(50);
        drain();

        // Largest mean velocity and widest channel.
        configure(32'sh7fff_ffff, AXIS_X, 31'h7fff_ffff);
        random_burst(50);
        drain();

        // No axis selected, then a zero width: both give zero outlet speed.
        configure(32'sh0002_0000, 2'd3, 31'h0002_0000);
        random_burst(40);
        drain();
        configure(32'shfffe_0000, AXIS_Y, 31'd0);
        random_burst(40);
        drain();

        // Random settings over the rest.
        for (int ph = 0; ph < 3; ph++) begin
            configure($urandom, 2'($urandom_range(0, 2)),
                      31'($urandom_range(1, 32'h0040_0000)));
            random_burst(45);
            drain();
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
